// ----- hdl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

    localparam int unsigned ChanWidth = 8;
    localparam int unsigned HueWidth  = 16;

    typedef logic [ChanWidth-1:0] chan_t;
    typedef logic [HueWidth-1:0]  hue_t;

    typedef struct packed {
        chan_t saturation;
        chan_t brightness;
    } hsv_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    // Sixths of the hue circle, named by the color range they span
    typedef enum logic [2:0] {
        SECT_RED_YELLOW     = 3'd0,
        SECT_YELLOW_GREEN   = 3'd1,
        SECT_GREEN_CYAN     = 3'd2,
        SECT_CYAN_BLUE      = 3'd3,
        SECT_BLUE_MAGENTA   = 3'd4,
        SECT_MAGENTA_RED    = 3'd5
    } sector_t;

endpackage

// ----- hdl/hsv2rgb_stream_if.sv -----
interface hsv2rgb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// ----- hdl/hsv_to_rgb_pixel.sv -----
// HSV to RGB pixel converter.
// Channels: hsv (sink) carries one pixel's saturation and brightness per item;
// rgb (source) returns red, green and blue, one item per input item, in order.
// cfg (sink) writes the 16-bit hue, a fraction of a full turn; it is always
// ready and is to be written only while no pixel is in flight.
// Pipeline: three register stages; an accepted item moves through them in order
// and shows on rgb from the third, where it can be taken.
// The stages are: saturation scaling by the hue fraction, the three
// brightness products, and the divide by 255 with the sector select.
// Throughput: one item per cycle while rgb.ready stays high; every stage holds
// a valid bit and moves whenever the stage after it is empty or moving.
// Stall: while rgb.ready is low the last stage holds its item; earlier
// stages keep filling until the pipeline is full, then hsv.ready drops.
// Nothing is dropped or repeated.
// Reset: all valid bits clear and the hue returns to zero (red sector).
module hsv_to_rgb_pixel (
    input  logic             clk,
    input  logic             rst_n,
    hsv2rgb_stream_if.sink   hsv,
    hsv2rgb_stream_if.source rgb,
    hsv2rgb_stream_if.sink   cfg
);

    // floor(x / 255) for any x up to 255 * 255, the largest product of two channels
    function automatic hsv2rgb_pkg::chan_t div255(input logic [15:0] x);
        logic [16:0] acc;
        begin
            acc = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
            div255 = acc[15:8];
        end
    endfunction

    hsv2rgb_pkg::hue_t hue_reg;

    // Stage 1: complemented scale factors
    logic                 s1_valid_reg;
    hsv2rgb_pkg::sector_t s1_sector_reg;
    hsv2rgb_pkg::chan_t   s1_v_reg;
    hsv2rgb_pkg::chan_t   s1_kp_reg;
    hsv2rgb_pkg::chan_t   s1_kq_reg;
    hsv2rgb_pkg::chan_t   s1_kt_reg;

    // Stage 2: brightness products
    logic                 s2_valid_reg;
    hsv2rgb_pkg::sector_t s2_sector_reg;
    hsv2rgb_pkg::chan_t   s2_v_reg;
    logic [15:0]          s2_pp_reg;
    logic [15:0]          s2_pq_reg;
    logic [15:0]          s2_pt_reg;

    // Stage 3: output register
    logic                 s3_valid_reg;
    hsv2rgb_pkg::rgb_t    s3_rgb_reg;

    logic adv1;
    logic adv2;
    logic adv3;

    logic [18:0]          hue6;
    hsv2rgb_pkg::sector_t s0_sector;
    logic [15:0]          s0_frac;
    logic [16:0]          s0_frac_inv;
    logic [23:0]          s0_sf;
    logic [24:0]          s0_sfi;

    hsv2rgb_pkg::chan_t   s2_p;
    hsv2rgb_pkg::chan_t   s2_q;
    hsv2rgb_pkg::chan_t   s2_t;
    hsv2rgb_pkg::rgb_t    s3_rgb_next;

    assign adv3 = !s3_valid_reg || rgb.ready;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;

    assign hsv.ready = adv1;
    assign cfg.ready = 1'b1;
    assign rgb.valid = s3_valid_reg;
    assign rgb.data  = s3_rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg <= '0;
        end
        else if (cfg.valid)
        begin
            hue_reg <= cfg.data;
        end
    end

    // Hue times six: integer part picks the sector, remainder is the fraction
    assign hue6        = {1'b0, hue_reg, 2'b00} + {2'b00, hue_reg, 1'b0};
    assign s0_sector   = hsv2rgb_pkg::sector_t'(hue6[18:16]);
    assign s0_frac     = hue6[15:0];
    assign s0_frac_inv = 17'h10000 - {1'b0, s0_frac};
    assign s0_sf       = {8'd0, s0_frac} * {16'd0, hsv.data.saturation};
    assign s0_sfi      = {8'd0, s0_frac_inv} * {17'd0, hsv.data.saturation};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= hsv.valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // 255 - x is the bitwise complement of an 8-bit x
    always_ff @(posedge clk)
    begin
        if (adv1 && hsv.valid)
        begin
            s1_sector_reg <= s0_sector;
            s1_v_reg      <= hsv.data.brightness;
            s1_kp_reg     <= ~hsv.data.saturation;
            s1_kq_reg     <= ~s0_sf[23:16];
            s1_kt_reg     <= ~s0_sfi[23:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_v_reg      <= s1_v_reg;
            s2_pp_reg     <= {8'd0, s1_v_reg} * {8'd0, s1_kp_reg};
            s2_pq_reg     <= {8'd0, s1_v_reg} * {8'd0, s1_kq_reg};
            s2_pt_reg     <= {8'd0, s1_v_reg} * {8'd0, s1_kt_reg};
        end
    end

    assign s2_p = div255(s2_pp_reg);
    assign s2_q = div255(s2_pq_reg);
    assign s2_t = div255(s2_pt_reg);

    always_comb
    begin
        unique case (s2_sector_reg)
            hsv2rgb_pkg::SECT_RED_YELLOW:
            begin
                s3_rgb_next = '{red: s2_v_reg, green: s2_t, blue: s2_p};
            end
            hsv2rgb_pkg::SECT_YELLOW_GREEN:
            begin
                s3_rgb_next = '{red: s2_q, green: s2_v_reg, blue: s2_p};
            end
            hsv2rgb_pkg::SECT_GREEN_CYAN:
            begin
                s3_rgb_next = '{red: s2_p, green: s2_v_reg, blue: s2_t};
            end
            hsv2rgb_pkg::SECT_CYAN_BLUE:
            begin
                s3_rgb_next = '{red: s2_p, green: s2_q, blue: s2_v_reg};
            end
            hsv2rgb_pkg::SECT_BLUE_MAGENTA:
            begin
                s3_rgb_next = '{red: s2_t, green: s2_p, blue: s2_v_reg};
            end
            default:
            begin
                s3_rgb_next = '{red: s2_v_reg, green: s2_p, blue: s2_q};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg)
        begin
            s3_rgb_reg <= s3_rgb_next;
        end
    end

endmodule

// ----- tb/sv/hsv_to_rgb_pixel_tb.sv -----
module hsv_to_rgb_pixel_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES       = 14;
    localparam int PHASE_PIXELS = 100;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AFTER   = 500;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_PROBES   = 22;

    typedef struct packed {
        hsv2rgb_pkg::hue_t  hue;
        hsv2rgb_pkg::chan_t sat;
        hsv2rgb_pkg::chan_t bri;
        logic               typed;
        hsv2rgb_pkg::rgb_t  rgb;
    } probe_t;

    // Rows with typed results are readable by hand; all others use the predictor.
    localparam probe_t PROBES [0:NUM_PROBES-1] = '{
        '{16'd0,     8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{16'd0,     8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'd0,     8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'd0,     8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'd0,     8'd128, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd10922, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd10922, 8'd77,  8'd181, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd10923, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd21845, 8'd200, 8'd100, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd21846, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd21846, 8'd1,   8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd32768, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
        '{16'd32768, 8'd90,  8'd170, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd43690, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd43691, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd43691, 8'd170, 8'd85,  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd54613, 8'd254, 8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd54614, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd65535, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd65535, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'd65535, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'd65535, 8'd33,  8'd222, 1'b0, '{8'd0,   8'd0,   8'd0}}
    };

    logic clk;
    logic rst_n;

    hsv2rgb_stream_if #(.payload_t(hsv2rgb_pkg::hsv_t)) hsv_if ();
    hsv2rgb_stream_if #(.payload_t(hsv2rgb_pkg::rgb_t)) rgb_if ();
    hsv2rgb_stream_if #(.payload_t(hsv2rgb_pkg::hue_t)) cfg_if ();

    hsv_to_rgb_pixel uut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv_if),
        .rgb   (rgb_if),
        .cfg   (cfg_if)
    );

    hsv2rgb_pkg::rgb_t pending_rgb [$];
    hsv2rgb_pkg::hue_t hue_now;
    int                error_count;
    int                cycle_count;
    int                rgb_seen;
    bit                sender_calm;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** hsv_to_rgb_pixel: FAILED **");
            $finish;
        end
    end

    function automatic hsv2rgb_pkg::rgb_t convert_hsv(hsv2rgb_pkg::hue_t hue,
                                                      hsv2rgb_pkg::hsv_t px);
        logic [18:0]          six_hue;
        hsv2rgb_pkg::sector_t sect;
        int unsigned          f, s, v, p, q, t;
        hsv2rgb_pkg::rgb_t    c;
        six_hue = hue * 19'd6;
        sect    = hsv2rgb_pkg::sector_t'(six_hue[18:16]);
        f       = six_hue[15:0];
        s       = px.saturation;
        v       = px.brightness;
        p       = v * (255 - s) / 255;
        q       = v * (255 - ((s * f) >> 16)) / 255;
        t       = v * (255 - ((s * (65536 - f)) >> 16)) / 255;
        case (sect)
            hsv2rgb_pkg::SECT_RED_YELLOW:   c = {8'(v), 8'(t), 8'(p)};
            hsv2rgb_pkg::SECT_YELLOW_GREEN: c = {8'(q), 8'(v), 8'(p)};
            hsv2rgb_pkg::SECT_GREEN_CYAN:   c = {8'(p), 8'(v), 8'(t)};
            hsv2rgb_pkg::SECT_CYAN_BLUE:    c = {8'(p), 8'(q), 8'(v)};
            hsv2rgb_pkg::SECT_BLUE_MAGENTA: c = {8'(t), 8'(p), 8'(v)};
            default:                        c = {8'(v), 8'(p), 8'(q)};
        endcase
        return c;
    endfunction

    function automatic hsv2rgb_pkg::chan_t pick_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return hsv2rgb_pkg::chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Hold valid through the handshake; push the expectation on acceptance.
    task automatic send_pixel(hsv2rgb_pkg::hsv_t px, hsv2rgb_pkg::rgb_t want);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            hsv_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hsv_if.valid <= 1'b1;
        hsv_if.data  <= px;
        do @(posedge clk); while (!hsv_if.ready);
        pending_rgb.push_back(want);
    endtask

    // Write the hue only with the pipeline drained.
    task automatic write_hue(hsv2rgb_pkg::hue_t hue);
        hsv_if.valid <= 1'b0;
        do @(posedge clk); while (pending_rgb.size() != 0);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= hue;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        hue_now = hue;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rgb_if.valid && rgb_if.ready)
        begin
            if (pending_rgb.size() == 0)
                flag_error($sformatf("unexpected result %0d,%0d,%0d", rgb_if.data.red,
                                     rgb_if.data.green, rgb_if.data.blue));
            else
            begin
                hsv2rgb_pkg::rgb_t want;
                want = pending_rgb.pop_front();
                if (rgb_if.data.red !== want.red)
                    flag_error($sformatf("red got %0d want %0d", rgb_if.data.red, want.red));
                if (rgb_if.data.green !== want.green)
                    flag_error($sformatf("green got %0d want %0d", rgb_if.data.green,
                                         want.green));
                if (rgb_if.data.blue !== want.blue)
                    flag_error($sformatf("blue got %0d want %0d", rgb_if.data.blue,
                                         want.blue));
            end
        end
    end

    // Result side: random stalls, calm stretches, and one long hold-off.
    initial
    begin
        int  wait_cycles;
        bit  held_off;
        rgb_if.ready = 1'b0;
        held_off     = 1'b0;
        rgb_seen     = 0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && rgb_seen >= HOLD_AFTER)
            begin
                wait_cycles = HOLD_CYCLES;
                held_off    = 1'b1;
            end
            else if ((rgb_seen / 64) % 4 == 1)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, 4);
            if (wait_cycles > 0)
            begin
                rgb_if.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            rgb_if.ready <= 1'b1;
            do @(posedge clk); while (!rgb_if.valid);
            rgb_seen++;
        end
    end

    initial
    begin
        hsv2rgb_pkg::hsv_t px;
        hsv2rgb_pkg::hue_t hue;
        hsv2rgb_pkg::hue_t edge_hues [0:5];
        error_count  = 0;
        cycle_count  = 0;
        hue_now      = '0;
        sender_calm  = 1'b0;
        edge_hues    = '{16'd65535, 16'd0, 16'd10923, 16'd43690, 16'd32767, 16'd54613};
        rst_n        = 1'b0;
        hsv_if.valid = 1'b0;
        hsv_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PROBES[i])
        begin
            if (PROBES[i].hue != hue_now)
                write_hue(PROBES[i].hue);
            px = '{PROBES[i].sat, PROBES[i].bri};
            send_pixel(px, PROBES[i].typed ? PROBES[i].rgb : convert_hsv(hue_now, px));
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            hue = (phase < 6) ? edge_hues[phase]
                              : hsv2rgb_pkg::hue_t'($urandom_range(0, 65535));
            write_hue(hue);
            sender_calm = (phase % 4 == 2);
            repeat (PHASE_PIXELS)
            begin
                px = '{pick_chan(), pick_chan()};
                send_pixel(px, convert_hsv(hue_now, px));
            end
        end
        sender_calm = 1'b0;

        hsv_if.valid <= 1'b0;
        do @(posedge clk); while (pending_rgb.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** hsv_to_rgb_pixel: PASSED **");
        else
            $display("** hsv_to_rgb_pixel: FAILED **");
        $finish;
    end

endmodule
